// ===== rtl/core/pfe_pkg.sv =====
package pfe_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int DATA_W          = 32;
    localparam int CHAR_W          = 8;
    localparam int STATUS_W        = 3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADCHAR  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEFTOVER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd5;

    localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_MUL  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DIV  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE  = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RD,
        S_DIV,
        S_WB,
        S_END,
        S_RES
    } t_state;

endpackage

// ===== rtl/core/pfe_in_if.sv =====
interface pfe_in_if
    import pfe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_expr;

    modport source (output valid, output char_code, output end_of_expr, input ready);
    modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

// ===== rtl/core/pfe_out_if.sv =====
interface pfe_out_if
    import pfe_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic        [STATUS_W-1:0] status;
    logic signed [DATA_W-1:0]   value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

// ===== rtl/core/pfe_stack.sv =====
module pfe_stack
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/core/pfe_div.sv =====
module pfe_div
    import pfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DATA_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_dmag;

    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_nmag;
    logic [DATA_W-1:0] w_dmag;

    assign w_nmag  = i_num[DATA_W-1] ? (DATA_W'(0) - i_num) : i_num;
    assign w_dmag  = i_den[DATA_W-1] ? (DATA_W'(0) - i_den) : i_den;
    assign w_trial = {r_rem, r_q[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one restoring step per cycle, quotient bits shift in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
            r_rem  <= '0;
            r_q    <= w_nmag;
            r_dmag <= w_dmag;
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DATA_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (DATA_W'(0) - r_q) : r_q;

endmodule

// ===== rtl/core/postfix_expression_evaluator_core.sv =====
// States per character: IDLE, EVAL, END for a digit, newline, bad character, operator without
// two operands or any character after an error; / by zero adds RD; + - * add RD and WB; / adds
// RD, DIV and WB, with DIV waiting on the 32-step radix-2 divider.
// The last character then also passes the result state, staying there while o_out still holds
// an earlier beat; its result beat is offered the cycle after.
// One character is in work at a time; a waiting result blocks only the next last character.
// Synchronous active-low reset clears the stack count, the latched error and the handshakes;
// stack memory contents are undefined until pushed.
module postfix_expression_evaluator_core
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfe_in_if.sink     i_in,
    pfe_out_if.source  o_out
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state              r_state, n_state;
    logic [CHAR_W-1:0]   r_ch, n_ch;
    logic                r_last, n_last;
    logic [CW-1:0]       r_count, n_count;
    logic [STATUS_W-1:0] r_err, n_err;
    logic [DATA_W-1:0]   r_res, n_res;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [DATA_W-1:0]   r_out_value, n_out_value;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr_a;
    logic [AW-1:0]     mem_raddr_b;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic              in_ready;
    logic              out_load;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;

    assign cnt_m1 = r_count - CW'(1);
    assign cnt_m2 = r_count - CW'(2);

    pfe_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_re     (mem_re),
        .i_raddr_a(mem_raddr_a),
        .i_raddr_b(mem_raddr_b),
        .o_rdata_a(rd_a),
        .o_rdata_b(rd_b)
    );

    pfe_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (rd_b),
        .i_den  (rd_a),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch         <= n_ch;
        r_last       <= n_last;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    always_comb begin
        n_state      = r_state;
        n_ch         = r_ch;
        n_last       = r_last;
        n_count      = r_count;
        n_err        = r_err;
        n_res        = r_res;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr_a  = '0;
        mem_raddr_b  = '0;
        div_start    = 1'b0;
        in_ready     = 1'b0;
        out_load     = 1'b0;

        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_ch    = i_in.char_code;
                    n_last  = i_in.end_of_expr;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_END;
                if (r_err == ST_OK) begin
                    case (r_ch) inside
                        [CH_ONE:CH_NINE]: begin
                            if (r_count >= CW'(STACK_DEPTH)) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = DATA_W'(r_ch - CH_ZERO);
                                n_count   = r_count + CW'(1);
                            end
                        end
                        CH_NL: begin
                        end
                        CH_PLUS, CH_MUL, CH_SUB, CH_DIV: begin
                            if (r_count < CW'(2)) begin
                                n_err = ST_MISSING;
                            end else begin
                                mem_re      = 1'b1;
                                mem_raddr_a = cnt_m1[AW-1:0];
                                mem_raddr_b = cnt_m2[AW-1:0];
                                n_state     = S_RD;
                            end
                        end
                        default: begin
                            n_err = ST_BADCHAR;
                        end
                    endcase
                end
            end
            S_RD: begin
                // rd_a is the top operand, rd_b the one below it
                case (r_ch)
                    CH_PLUS: begin
                        n_res   = rd_b + rd_a;
                        n_state = S_WB;
                    end
                    CH_MUL: begin
                        n_res   = rd_b * rd_a;
                        n_state = S_WB;
                    end
                    CH_SUB: begin
                        n_res   = rd_b - rd_a;
                        n_state = S_WB;
                    end
                    default: begin
                        if (rd_a == '0) begin
                            n_err   = ST_DIVZERO;
                            n_state = S_END;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = div_quot;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_m2[AW-1:0];
                mem_wdata = r_res;
                n_count   = cnt_m1;
                n_state   = S_END;
            end
            S_END: begin
                if (r_last) begin
                    mem_re      = 1'b1;
                    mem_raddr_a = '0;
                    n_state     = S_RES;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RES: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    out_load    = 1'b1;
                    n_out_value = '0;
                    if (r_err != ST_OK) begin
                        n_out_status = r_err;
                    end else if (r_count == '0) begin
                        n_out_status = ST_MISSING;
                    end else if (r_count > CW'(1)) begin
                        n_out_status = ST_LEFTOVER;
                    end else begin
                        n_out_status = ST_OK;
                        n_out_value  = rd_a;
                    end
                    n_count = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign i_in.ready   = in_ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.value  = $signed(r_out_value);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_beat_from_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_RES)
        else $error("result beat raised outside result state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

    a_clear_after_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_count == '0) && (r_err == ST_OK) && (r_state == S_IDLE))
        else $error("stack or error not cleared after result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_status <= ST_DIVZERO)
        else $error("status code out of range");

endmodule
